@@ rtl/core/efrs_pkg.sv @@
// shared constants and types for the earliest-free room scheduler
package efrs_pkg;

    // default build parameters
    localparam int ROOMS_DEF      = 16;
    localparam int TIME_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 16;

    // fixed field widths
    localparam int IN_TIME_W  = 32;
    localparam int FINISH_W   = 40;
    localparam int ROOM_OUT_W = 4;
    localparam int CFG_W      = 5;

    localparam logic [CFG_W-1:0] ROOMS_IN_USE_RST = 5'd16;

    // control of the room memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } mem_ctl_t;

    // one result item
    typedef struct packed {
        logic [ROOM_OUT_W-1:0] assigned_room;
        logic [FINISH_W-1:0]   finish_time;
        logic                  set_done;
        logic [ROOM_OUT_W-1:0] busiest_room;
        logic                  order_error;
    } rsp_t;

endpackage

@@ rtl/core/efrs_req_if.sv @@
// request and response channel interfaces
interface efrs_req_if;
    logic                            valid;
    logic                            ready;
    logic [efrs_pkg::IN_TIME_W-1:0]  start_time;
    logic [efrs_pkg::IN_TIME_W-1:0]  stop_time;
    logic                            last_request;

    modport source (output valid, start_time, stop_time, last_request, input ready);
    modport sink (input valid, start_time, stop_time, last_request, output ready);
endinterface

interface efrs_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [efrs_pkg::ROOM_OUT_W-1:0]  assigned_room;
    logic [efrs_pkg::FINISH_W-1:0]    finish_time;
    logic                             set_done;
    logic [efrs_pkg::ROOM_OUT_W-1:0]  busiest_room;
    logic                             order_error;

    modport source (output valid, assigned_room, finish_time, set_done, busiest_room,
                    order_error, input ready);
    modport sink (input valid, assigned_room, finish_time, set_done, busiest_room,
                  order_error, output ready);
endinterface

@@ rtl/core/earliest_free_room_scheduler_core.sv @@
// top level of the earliest-free room scheduler
//
// req channel: valid/ready request carrying start_time, stop_time and
// last_request; requests are expected in ascending start order.
// rsp channel: valid/ready response with assigned_room, finish_time,
// set_done, busiest_room and order_error; one response per request.
// cfg port: cfg_wr_en writes cfg_wr_data into rooms_in_use (reset 16);
// zero acts as one room, values above ROOMS act as ROOMS.
// sequence, n = active room count:
//   in-order request: n room reads, the data of the last read, a write-back
//   of the chosen room and the response load, in that order;
//   a last request adds a busiest-room scan over the n rooms before the load;
//   an out-of-order request that is not last goes straight to the load.
// one request is in flight at a time; the next can be accepted in the cycle
// after its response is loaded into the output register, even if rsp is stalled.
// a stalled rsp holds its response and the sequencer waits to load the next.
// reset clears all room state, previous start and the output valid;
// a last request clears the room state and previous start once answered.
module earliest_free_room_scheduler_core #(
    parameter int ROOMS      = efrs_pkg::ROOMS_DEF,
    parameter int TIME_BITS  = efrs_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = efrs_pkg::COUNT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    efrs_req_if.sink                    req,
    efrs_rsp_if.source                  rsp,
    input  logic                        cfg_wr_en,
    input  logic [efrs_pkg::CFG_W-1:0]  cfg_wr_data
);

    localparam int RW = (ROOMS > 1) ? $clog2(ROOMS) : 1;
    localparam int TB = (TIME_BITS < efrs_pkg::IN_TIME_W) ? TIME_BITS : efrs_pkg::IN_TIME_W;
    localparam int DW = efrs_pkg::FINISH_W + COUNT_BITS;
    localparam logic [8:0] ROOMS_W9 = 9'(ROOMS);

    logic [efrs_pkg::CFG_W-1:0] rooms_in_use_reg;
    logic [8:0]                 n_m1;
    logic [RW-1:0]              last_idx;
    efrs_pkg::mem_ctl_t         mem_ctl;
    logic [RW-1:0]              mem_raddr;
    logic [RW-1:0]              mem_waddr;
    logic [DW-1:0]              mem_wdata;
    logic [DW-1:0]              mem_rdata;
    logic                       res_free;
    logic                       res_valid;
    efrs_pkg::rsp_t             res;
    logic                       rsp_valid_reg;
    efrs_pkg::rsp_t             rsp_data_reg;

    // room count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rooms_in_use_reg <= efrs_pkg::ROOMS_IN_USE_RST;
        end
        else if (cfg_wr_en)
        begin
            rooms_in_use_reg <= cfg_wr_data;
        end
    end

    // highest room index taking part in the scan
    always_comb
    begin
        if (rooms_in_use_reg == '0)
        begin
            n_m1 = '0;
        end
        else if (9'(rooms_in_use_reg) > ROOMS_W9)
        begin
            n_m1 = ROOMS_W9 - 9'd1;
        end
        else
        begin
            n_m1 = 9'(rooms_in_use_reg) - 9'd1;
        end
    end
    assign last_idx = RW'(n_m1);

    efrs_room_mem #(
        .DEPTH (ROOMS),
        .AW    (RW),
        .DW    (DW)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mem_ctl),
        .raddr (mem_raddr),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    efrs_ctrl #(
        .RW (RW),
        .TB (TB),
        .CB (COUNT_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_start (req.start_time[TB-1:0]),
        .req_end   (req.stop_time[TB-1:0]),
        .req_last  (req.last_request),
        .last_idx  (last_idx),
        .mem_ctl   (mem_ctl),
        .mem_raddr (mem_raddr),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register
    assign res_free = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.assigned_room = rsp_data_reg.assigned_room;
    assign rsp.finish_time   = rsp_data_reg.finish_time;
    assign rsp.set_done      = rsp_data_reg.set_done;
    assign rsp.busiest_room  = rsp_data_reg.busiest_room;
    assign rsp.order_error   = rsp_data_reg.order_error;

endmodule

@@ rtl/core/efrs_room_mem.sv @@
// per-room state memory with valid bits and registered read
module efrs_room_mem #(
    parameter int DEPTH = efrs_pkg::ROOMS_DEF,
    parameter int AW    = 4,
    parameter int DW    = 56
) (
    input  logic               clk,
    input  logic               rst_n,
    input  efrs_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]      raddr,
    input  logic [AW-1:0]      waddr,
    input  logic [DW-1:0]      wdata,
    output logic [DW-1:0]      rdata
);

    logic [DW-1:0]    room_mem [0:DEPTH-1];
    logic [DW-1:0]    rd_data_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             rd_vld_reg;

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            room_mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= room_mem[raddr];
        end
    end

    // entry valid bits, cleared at reset and at end of set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr)
            begin
                vld_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_vld_reg <= vld_reg[raddr];
            end
        end
    end

    // entry never written since clear reads as zero
    assign rdata = rd_vld_reg ? rd_data_reg : '0;

endmodule

@@ rtl/core/efrs_ctrl.sv @@
// request sequencer: room scan, read-modify-write update, busiest-room scan
module efrs_ctrl #(
    parameter int RW     = 4,
    parameter int TB     = 32,
    parameter int CB     = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [TB-1:0]                 req_start,
    input  logic [TB-1:0]                 req_end,
    input  logic                          req_last,
    input  logic [RW-1:0]                 last_idx,
    output efrs_pkg::mem_ctl_t            mem_ctl,
    output logic [RW-1:0]                 mem_raddr,
    output logic [RW-1:0]                 mem_waddr,
    output logic [efrs_pkg::FINISH_W+CB-1:0] mem_wdata,
    input  logic [efrs_pkg::FINISH_W+CB-1:0] mem_rdata,
    input  logic                          res_free,
    output logic                          res_valid,
    output efrs_pkg::rsp_t                res
);

    localparam int FW = efrs_pkg::FINISH_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_UPD   = 5'b00100,
        S_BSCAN = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [TB-1:0] start_reg, start_next;
    logic [TB-1:0] dur_reg, dur_next;
    logic [TB-1:0] prev_reg, prev_next;
    logic          last_reg, last_next;
    logic          err_reg, err_next;
    logic [RW-1:0] idx_reg, idx_next;
    logic          iss_reg, iss_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [RW-1:0] rd_idx_reg, rd_idx_next;
    logic          found_reg, found_next;
    logic [RW-1:0] room_reg, room_next;
    logic [CB-1:0] free_cnt_reg, free_cnt_next;
    logic [FW-1:0] min_val_reg, min_val_next;
    logic [RW-1:0] min_room_reg, min_room_next;
    logic [CB-1:0] min_cnt_reg, min_cnt_next;
    logic [CB-1:0] best_cnt_reg, best_cnt_next;
    logic [RW-1:0] best_room_reg, best_room_next;
    logic [FW-1:0] finish_reg, finish_next;

    logic [FW-1:0] rd_busy;
    logic [CB-1:0] rd_cnt;
    logic [FW-1:0] upd_begin;
    logic [CB-1:0] upd_cnt;
    logic [FW:0]   upd_sum;
    logic [FW-1:0] upd_finish;
    logic [CB-1:0] upd_cnt_inc;
    logic          scan_end;

    assign rd_busy  = mem_rdata[FW+CB-1:CB];
    assign rd_cnt   = mem_rdata[CB-1:0];
    assign scan_end = rd_pend_reg && (rd_idx_reg == last_idx);

    // chosen room: first free one, else earliest to free
    assign upd_begin   = found_reg ? FW'(start_reg) : min_val_reg;
    assign upd_cnt     = found_reg ? free_cnt_reg : min_cnt_reg;
    assign upd_sum     = (FW+1)'(upd_begin) + (FW+1)'(dur_reg);
    assign upd_finish  = upd_sum[FW] ? '1 : upd_sum[FW-1:0];
    assign upd_cnt_inc = (upd_cnt == '1) ? upd_cnt : upd_cnt + CB'(1);

    assign req_ready = (state_reg == S_IDLE);

    // next-state and datapath
    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        dur_next       = dur_reg;
        prev_next      = prev_reg;
        last_next      = last_reg;
        err_next       = err_reg;
        idx_next       = idx_reg;
        iss_next       = iss_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = idx_reg;
        found_next     = found_reg;
        room_next      = room_reg;
        free_cnt_next  = free_cnt_reg;
        min_val_next   = min_val_reg;
        min_room_next  = min_room_reg;
        min_cnt_next   = min_cnt_reg;
        best_cnt_next  = best_cnt_reg;
        best_room_next = best_room_reg;
        finish_next    = finish_reg;
        mem_ctl        = '0;
        mem_raddr      = idx_reg;
        mem_waddr      = found_reg ? room_reg : min_room_reg;
        mem_wdata      = {upd_finish, upd_cnt_inc};
        res_valid      = 1'b0;

        // read issue shared by both scans
        if ((state_reg == S_SCAN || state_reg == S_BSCAN) && iss_reg)
        begin
            mem_ctl.rd_en = 1'b1;
            rd_pend_next  = 1'b1;
            if (idx_reg == last_idx)
            begin
                iss_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + RW'(1);
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    start_next  = req_start;
                    dur_next    = (req_end > req_start) ? req_end - req_start : '0;
                    last_next   = req_last;
                    err_next    = req_start < prev_reg;
                    idx_next    = '0;
                    iss_next    = 1'b1;
                    found_next  = 1'b0;
                    room_next   = '0;
                    finish_next = '0;
                    if (req_start < prev_reg)
                    begin
                        state_next = req_last ? S_BSCAN : S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (rd_pend_reg)
                begin
                    if (!found_reg && rd_busy <= FW'(start_reg))
                    begin
                        found_next    = 1'b1;
                        room_next     = rd_idx_reg;
                        free_cnt_next = rd_cnt;
                    end
                    if (rd_idx_reg == '0 || rd_busy < min_val_reg)
                    begin
                        min_val_next  = rd_busy;
                        min_room_next = rd_idx_reg;
                        min_cnt_next  = rd_cnt;
                    end
                end
                if (scan_end)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                mem_ctl.wr_en = 1'b1;
                room_next     = mem_waddr;
                finish_next   = upd_finish;
                prev_next     = start_reg;
                idx_next      = '0;
                iss_next      = 1'b1;
                state_next    = last_reg ? S_BSCAN : S_DONE;
            end
            S_BSCAN:
            begin
                if (rd_pend_reg && (rd_idx_reg == '0 || rd_cnt > best_cnt_reg))
                begin
                    best_cnt_next  = rd_cnt;
                    best_room_next = rd_idx_reg;
                end
                if (scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                    if (last_reg)
                    begin
                        mem_ctl.clr = 1'b1;
                        prev_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result fields
    always_comb
    begin
        res.assigned_room = efrs_pkg::ROOM_OUT_W'(room_reg);
        res.finish_time   = finish_reg;
        res.set_done      = last_reg;
        res.busiest_room  = last_reg ? efrs_pkg::ROOM_OUT_W'(best_room_reg) : '0;
        res.order_error   = err_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            prev_reg    <= '0;
            iss_reg     <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            prev_reg    <= prev_next;
            iss_reg     <= iss_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        start_reg     <= start_next;
        dur_reg       <= dur_next;
        last_reg      <= last_next;
        err_reg       <= err_next;
        idx_reg       <= idx_next;
        rd_idx_reg    <= rd_idx_next;
        found_reg     <= found_next;
        room_reg      <= room_next;
        free_cnt_reg  <= free_cnt_next;
        min_val_reg   <= min_val_next;
        min_room_reg  <= min_room_next;
        min_cnt_reg   <= min_cnt_next;
        best_cnt_reg  <= best_cnt_next;
        best_room_reg <= best_room_next;
        finish_reg    <= finish_next;
    end

endmodule

@@ rtl/core/efrs_checker.sv @@
// port-level checks for the scheduler core and their binding
module efrs_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [efrs_pkg::ROOM_OUT_W-1:0]  rsp_room,
    input logic [efrs_pkg::FINISH_W-1:0]    rsp_finish,
    input logic                             rsp_done,
    input logic [efrs_pkg::ROOM_OUT_W-1:0]  rsp_busiest,
    input logic                             rsp_err
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_room)
            && $stable(rsp_finish) && $stable(rsp_done) && $stable(rsp_err))
        else $error("stalled response changed");

    // one request in flight: ready drops after accept
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // ignored request reports no room and no finish time
    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_err |-> rsp_room == '0 && rsp_finish == '0)
        else $error("order error with room data");

    // busiest room only reported at end of set
    a_busiest_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_done |-> rsp_busiest == '0)
        else $error("busiest room outside end of set");

endmodule

bind earliest_free_room_scheduler_core efrs_checker u_efrs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_room    (rsp.assigned_room),
    .rsp_finish  (rsp.finish_time),
    .rsp_done    (rsp.set_done),
    .rsp_busiest (rsp.busiest_room),
    .rsp_err     (rsp.order_error)
);

@@ tb/sv/tb.sv @@
// testbench for the earliest-free room scheduler core
module tb;

    localparam int ROOMS_MAX    = efrs_pkg::ROOMS_DEF;
    localparam int DRAIN_CYCLES = 2 * ROOMS_MAX + 8;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 155;
    localparam logic [efrs_pkg::CFG_W-1:0] PHASE_ROOMS [PHASES] = '{5'd16, 5'd1, 5'd8, 5'd31,
                                                                   5'd5, 5'd0, 5'd17, 5'd12};
    localparam logic [efrs_pkg::FINISH_W-1:0] FINISH_SAT = {efrs_pkg::FINISH_W{1'b1}};

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [efrs_pkg::CFG_W-1:0] cfg_wr_data;

    efrs_req_if req ();
    efrs_rsp_if rsp ();

    earliest_free_room_scheduler_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // room schedule mirror
    logic [efrs_pkg::FINISH_W-1:0]  room_free_at  [ROOMS_MAX];
    logic [15:0]                    room_bookings [ROOMS_MAX];
    logic [efrs_pkg::IN_TIME_W-1:0] last_start;
    logic [efrs_pkg::CFG_W-1:0]     room_limit;

    // expected bookings in request order
    efrs_pkg::rsp_t booking_queue[$];

    int  fail_count;
    bit  idle_on;
    int  stall_left;
    int  hold_left;

    // random set shape
    int          set_pos;
    int          set_goal;
    int unsigned step_max;
    int unsigned dur_max;

    // clock
    always #6 clk = ~clk;

    // run limit
    initial
    begin
        #(12 * 1000000);
        $display("CHECKS FAILED");
        $finish;
    end

    // clear the room schedule, as after reset or a last request
    function automatic void clear_schedule();
        for (int k = 0; k < ROOMS_MAX; k++)
        begin
            room_free_at[k]  = '0;
            room_bookings[k] = '0;
        end
        last_start = '0;
    endfunction

    // expected answer for one booking; updates the mirror
    function automatic efrs_pkg::rsp_t book_room(input logic [efrs_pkg::IN_TIME_W-1:0] s,
                                                 input logic [efrs_pkg::IN_TIME_W-1:0] e,
                                                 input logic is_last);
        efrs_pkg::rsp_t r;
        int n;
        int pick;
        int best;
        bit found;
        logic [efrs_pkg::IN_TIME_W-1:0] dur;
        logic [efrs_pkg::FINISH_W-1:0]  start_at;
        logic [efrs_pkg::FINISH_W:0]    fin;
        r = '0;
        n = (room_limit == 0) ? 1 : ((room_limit > ROOMS_MAX) ? ROOMS_MAX : int'(room_limit));
        if (s < last_start)
        begin
            r.order_error = 1'b1;
        end
        else
        begin
            dur = (e > s) ? e - s : '0;
            found = 0;
            pick = 0;
            // lowest free room
            for (int k = 0; k < n; k++)
            begin
                if (!found && room_free_at[k] <= {8'h00, s})
                begin
                    pick = k;
                    found = 1;
                end
            end
            // otherwise the room that frees first
            if (!found)
            begin
                for (int k = 1; k < n; k++)
                begin
                    if (room_free_at[k] < room_free_at[pick])
                        pick = k;
                end
            end
            start_at = found ? {8'h00, s} : room_free_at[pick];
            fin = {1'b0, start_at} + dur;
            if (fin[efrs_pkg::FINISH_W])
                fin = {1'b0, FINISH_SAT};
            room_free_at[pick] = fin[efrs_pkg::FINISH_W-1:0];
            if (room_bookings[pick] != 16'hFFFF)
                room_bookings[pick] = room_bookings[pick] + 1'b1;
            last_start = s;
            r.assigned_room = pick[efrs_pkg::ROOM_OUT_W-1:0];
            r.finish_time = fin[efrs_pkg::FINISH_W-1:0];
        end
        if (is_last)
        begin
            best = 0;
            for (int k = 1; k < n; k++)
            begin
                if (room_bookings[k] > room_bookings[best])
                    best = k;
            end
            r.set_done = 1'b1;
            r.busiest_room = best[efrs_pkg::ROOM_OUT_W-1:0];
            clear_schedule();
        end
        return r;
    endfunction

    // response check
    always @(posedge clk)
    begin
        efrs_pkg::rsp_t got;
        efrs_pkg::rsp_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.assigned_room = rsp.assigned_room;
            got.finish_time   = rsp.finish_time;
            got.set_done      = rsp.set_done;
            got.busiest_room  = rsp.busiest_room;
            got.order_error   = rsp.order_error;
            if (booking_queue.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected response: room %0d finish %0h", got.assigned_room,
                             got.finish_time);
            end
            else
            begin
                want = booking_queue.pop_front();
                if (got.assigned_room !== want.assigned_room ||
                    got.finish_time !== want.finish_time ||
                    got.set_done !== want.set_done ||
                    got.busiest_room !== want.busiest_room ||
                    got.order_error !== want.order_error)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $write("mismatch: expected room %0d finish %0h done %0b busiest %0d ",
                               want.assigned_room, want.finish_time, want.set_done,
                               want.busiest_room);
                        $display("err %0b, got room %0d finish %0h done %0b busiest %0d err %0b",
                                 want.order_error, got.assigned_room, got.finish_time,
                                 got.set_done, got.busiest_room, got.order_error);
                    end
                end
            end
        end
    end

    // long receiver hold-off counter
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // response ready with random stall bursts
    always @(posedge clk)
    begin
        if (!rst_n || hold_left != 0)
        begin
            rsp.ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            rsp.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 15) == 0)
        begin
            rsp.ready <= 1'b0;
            stall_left <= $urandom_range(0, 18);
        end
        else
        begin
            rsp.ready <= 1'b1;
        end
    end

    // offer one request and wait until it is taken
    task automatic send_request(input logic [efrs_pkg::IN_TIME_W-1:0] s,
                                input logic [efrs_pkg::IN_TIME_W-1:0] e,
                                input logic is_last);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.start_time   <= s;
        req.stop_time    <= e;
        req.last_request <= is_last;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        booking_queue.push_back(book_room(s, e, is_last));
    endtask

    // stop offering and wait for every outstanding response
    task automatic wait_drained();
        req.valid <= 1'b0;
        while (booking_queue.size() != 0)
            @(posedge clk);
    endtask

    // room count write while idle
    task automatic write_rooms(input logic [efrs_pkg::CFG_W-1:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        room_limit = v;
    endtask

    // one random request, mostly well-formed ascending sets
    task automatic random_booking();
        logic [efrs_pkg::IN_TIME_W:0] s_wide;
        logic [efrs_pkg::IN_TIME_W:0] e_wide;
        int kind;
        // new set shape
        if (set_pos == 0)
        begin
            set_goal = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120)
                                                   : $urandom_range(1, 40);
            case ($urandom_range(0, 4))
                0: step_max = 0;
                1: step_max = 3;
                2: step_max = 50;
                3: step_max = 5000;
                default: step_max = 1 << 20;
            endcase
            case ($urandom_range(0, 4))
                0: dur_max = 1;
                1: dur_max = 20;
                2: dur_max = 300;
                3: dur_max = 100000;
                default: dur_max = 32'h8000_0000;
            endcase
        end
        kind = $urandom_range(0, 99);
        if (kind < 85)
        begin
            if (set_pos == 0 && $urandom_range(0, 3) == 0)
                s_wide = {1'b0, $urandom()};
            else
                s_wide = {1'b0, last_start} + $urandom_range(0, step_max);
            if (s_wide[efrs_pkg::IN_TIME_W])
                s_wide = {1'b0, {efrs_pkg::IN_TIME_W{1'b1}}};
            e_wide = s_wide + $urandom_range(1, dur_max);
            if (e_wide[efrs_pkg::IN_TIME_W])
                e_wide = {1'b0, {efrs_pkg::IN_TIME_W{1'b1}}};
        end
        else if (kind < 91 && last_start != 0)
        begin
            // start below the previous one
            s_wide = {1'b0, 32'($urandom_range(0, last_start - 1))};
            e_wide = s_wide + $urandom_range(0, 100);
        end
        else if (kind < 96)
        begin
            // end not above start
            s_wide = {1'b0, last_start} + $urandom_range(0, 20);
            if (s_wide[efrs_pkg::IN_TIME_W])
                s_wide = {1'b0, {efrs_pkg::IN_TIME_W{1'b1}}};
            e_wide = {1'b0, 32'($urandom_range(0, s_wide[efrs_pkg::IN_TIME_W-1:0]))};
        end
        else
        begin
            s_wide = {1'b0, $urandom()};
            e_wide = {1'b0, $urandom()};
        end
        set_pos++;
        if (set_pos >= set_goal)
            set_pos = 0;
        send_request(s_wide[efrs_pkg::IN_TIME_W-1:0], e_wide[efrs_pkg::IN_TIME_W-1:0],
                     set_pos == 0);
    endtask

    // free rooms, equal boundary, zero duration, order error, top of range
    task automatic test_basic_assignment();
        send_request(32'd0, 32'd10, 1'b0);
        send_request(32'd0, 32'd5, 1'b0);
        send_request(32'd5, 32'd7, 1'b0);
        send_request(32'd6, 32'd6, 1'b0);
        send_request(32'd7, 32'd3, 1'b0);
        send_request(32'd2, 32'd9, 1'b0);
        send_request(32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    endtask

    // one room, and a count of zero acting as one
    task automatic test_single_room();
        write_rooms(5'd1);
        send_request(32'd0, 32'd100, 1'b0);
        send_request(32'd10, 32'd20, 1'b0);
        send_request(32'd20, 32'd30, 1'b1);
        write_rooms(5'd0);
        send_request(32'd5, 32'd50, 1'b0);
        send_request(32'd6, 32'd9, 1'b0);
        send_request(32'd1, 32'd2, 1'b1);
    endtask

    // delays and a busiest room other than zero
    task automatic test_delay_and_busiest();
        write_rooms(5'd2);
        send_request(32'd0, 32'd50, 1'b0);
        send_request(32'd0, 32'd30, 1'b0);
        send_request(32'd10, 32'd20, 1'b0);
        send_request(32'd12, 32'd13, 1'b0);
        send_request(32'd5, 32'd6, 1'b1);
    endtask

    // rooms beyond a reduced count keep state but are skipped
    task automatic test_room_limit();
        write_rooms(5'd16);
        send_request(32'd100, 32'd1000, 1'b0);
        send_request(32'd100, 32'd1100, 1'b0);
        send_request(32'd100, 32'd1200, 1'b0);
        send_request(32'd100, 32'd900, 1'b0);
        write_rooms(5'd3);
        send_request(32'd200, 32'd300, 1'b0);
        send_request(32'd250, 32'd260, 1'b1);
        write_rooms(5'd31);
        send_request(32'd7, 32'd8, 1'b1);
    endtask

    // finish time saturation on one room with long delayed bookings
    task automatic test_finish_saturation();
        logic [efrs_pkg::IN_TIME_W-1:0] s;
        write_rooms(5'd1);
        s = '0;
        for (int k = 0; k < 270; k++)
        begin
            s = s + $urandom_range(0, 3);
            send_request(s, 32'hFFFF_FFFF - $urandom_range(0, 15), k == 269);
        end
    endtask

    // receiver holds off while requests keep coming, then sender drains
    task automatic test_backpressure();
        write_rooms(5'd16);
        idle_on = 0;
        hold_left <= 150;
        for (int k = 0; k < 12; k++)
            send_request(32'd1000 + k, 32'd1500 + 7 * k, k == 11);
        wait_drained();
    endtask

    // random sets across several room counts
    task automatic test_random_traffic();
        set_pos = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            write_rooms(PHASE_ROOMS[p]);
            idle_on = (p != PHASES - 1);
            repeat (PHASE_ITEMS) random_booking();
        end
    endtask

    initial
    begin
        int guard;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        req.valid = 1'b0;
        req.start_time = '0;
        req.stop_time = '0;
        req.last_request = 1'b0;
        rsp.ready = 1'b0;
        fail_count = 0;
        idle_on = 0;
        stall_left = 0;
        hold_left = 0;
        set_pos = 0;
        set_goal = 1;
        step_max = 0;
        dur_max = 1;
        clear_schedule();
        room_limit = efrs_pkg::ROOMS_IN_USE_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        idle_on = 1;
        test_basic_assignment();
        test_single_room();
        test_delay_and_busiest();
        test_room_limit();
        test_finish_saturation();
        test_backpressure();
        idle_on = 1;
        test_random_traffic();

        // final drain
        req.valid <= 1'b0;
        idle_on = 0;
        guard = 0;
        while (booking_queue.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (booking_queue.size() != 0)
            $display("%0d responses never arrived", booking_queue.size());
        if (fail_count == 0 && booking_queue.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/efrs_pkg.sv
rtl/core/efrs_req_if.sv
rtl/core/efrs_room_mem.sv
rtl/core/efrs_ctrl.sv
rtl/core/earliest_free_room_scheduler_core.sv
rtl/core/efrs_checker.sv
tb/sv/tb.sv
